/* design/msm_pkg.sv */
// ============================================================================
// msm_pkg : shared types and codes for the multi-string prefix matcher
// Request and result payloads, command codes and result status codes.
// ============================================================================
package msm_pkg;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // result status codes
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_MATCHED = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_DECIDED = 3'd4;

    // match length saturates here
    localparam int LEN_SAT = 15;

    typedef struct packed {
        logic        command;
        logic [2:0]  position;
        logic [7:0]  byte_value;
        logic [31:0] match_mask;
        logic [31:0] end_mask;
        logic        first_byte;
        logic        last_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] string_id;
        logic [3:0] match_length;
    } t_out_rsp;

endpackage

/* design/multi_string_prefix_matcher_top.sv */
// ============================================================================
// multi_string_prefix_matcher_top : bit-parallel multi-string prefix matcher
// Matches the head of a byte stream against up to NUM_STRINGS strings using
// (position, byte) indexed match/end mask tables held in block memory.
// ============================================================================
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  request  | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_req)
//  result   | out       | o_out_valid / i_out_ready  | o_out_data (t_out_rsp)
//
//  - One request per cycle sustained unless a stalled result holds the
//    decide stage. A table write gives no result; for a subject byte the
//    table read is registered at the accepting edge, and the mask/decide
//    stage then loads the output register when it advances.
//  - The rate is set by the single alive-mask update loop in the decide stage
//    and the one read port of each table memory.
//  - After reset the tables are swept to zero, one entry per cycle, over all
//    MAX_LEN*256 entries (2048 at MAX_LEN = 8); o_in_ready stays low meanwhile.
//  - A stalled result holds the decide stage; o_in_ready is low whenever that
//    stage is full and cannot advance, so at most one subject byte waits
//    behind a stalled output.
//
module multi_string_prefix_matcher_top #(
    parameter int MAX_LEN     = 8,
    parameter int NUM_STRINGS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  msm_pkg::t_in_req   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output msm_pkg::t_out_rsp  o_out_data
);
    import msm_pkg::*;

    // table geometry: entry address is {position, byte}
    localparam int DEPTH = MAX_LEN * 256;
    localparam int LW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW    = LW + 8;
    // byte position counts up to MAX_LEN inclusive
    localparam int PW    = $clog2(MAX_LEN + 1);
    localparam int XW    = (PW > 3) ? PW : 3;
    localparam logic [NUM_STRINGS-1:0] ALL_ALIVE = '1;

    // lowest set bit index (priority encoder)
    function automatic logic [4:0] f_lowest(input logic [NUM_STRINGS-1:0] m);
        logic [4:0] k;
        k = '0;
        for (int i = NUM_STRINGS - 1; i >= 0; i--) begin
            if (m[i]) begin
                k = 5'(i);
            end
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // table memories
    // ------------------------------------------------------------------
    logic [NUM_STRINGS-1:0] mem_match [DEPTH];
    logic [NUM_STRINGS-1:0] mem_end   [DEPTH];
    logic [NUM_STRINGS-1:0] r_mm_q;
    logic [NUM_STRINGS-1:0] r_em_q;

    // clearing sweep after reset
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // request acceptance
    logic in_acc;
    logic acc_wr;
    logic acc_match;

    // write port
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [NUM_STRINGS-1:0] wr_mm;
    logic [NUM_STRINGS-1:0] wr_em;
    logic [XW-1:0]          wr_pos;

    // read port: position is tracked ahead of the decide stage. It only
    // diverges from the real position once a subject is decided, and then
    // the table data is not used.
    logic [PW-1:0] r_rd_pos;
    logic [PW-1:0] rd_pos;
    logic [AW-1:0] rd_addr;

    // decide stage
    logic r_s1_valid;
    logic r_s1_first;
    logic r_s1_last;
    logic s1_adv;

    // per-subject state
    logic [NUM_STRINGS-1:0] r_alive;
    logic [PW-1:0]          r_pos;
    logic [4:0]             r_ended_id;
    logic [3:0]             r_ended_len;
    logic                   r_have_ended;
    logic                   r_decided;

    logic [NUM_STRINGS-1:0] n_alive;
    logic [PW-1:0]          n_pos;
    logic [4:0]             n_ended_id;
    logic [3:0]             n_ended_len;
    logic                   n_have_ended;
    logic                   n_decided;
    t_out_rsp               n_rsp;

    // output register
    logic     r_out_valid;
    t_out_rsp r_out_data;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;
    assign acc_wr     = in_acc && (i_in_data.command == CMD_WRITE);
    assign acc_match  = in_acc && (i_in_data.command == CMD_MATCH);

    assign wr_pos = XW'(i_in_data.position);

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_mm   = '0;
            wr_em   = '0;
        end else begin
            wr_en   = acc_wr && (int'(i_in_data.position) < MAX_LEN);
            wr_addr = {wr_pos[LW-1:0], i_in_data.byte_value};
            wr_mm   = i_in_data.match_mask[NUM_STRINGS-1:0];
            wr_em   = i_in_data.end_mask[NUM_STRINGS-1:0];
        end
    end

    // a new subject reads at position zero; out-of-range positions read
    // the position-zero row at that byte (result unused, subject is already decided)
    always_comb begin
        rd_pos = i_in_data.first_byte ? '0 : r_rd_pos;
        if (int'(rd_pos) < MAX_LEN) begin
            rd_addr = {rd_pos[LW-1:0], i_in_data.byte_value};
        end else begin
            rd_addr = {LW'(0), i_in_data.byte_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_match[wr_addr] <= wr_mm;
            mem_end[wr_addr]   <= wr_em;
        end
        if (acc_match) begin
            r_mm_q <= mem_match[rd_addr];
            r_em_q <= mem_end[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // read-side position tracker, saturating at MAX_LEN
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
        end else if (acc_match) begin
            if (int'(rd_pos) < MAX_LEN) begin
                r_rd_pos <= rd_pos + 1'b1;
            end else begin
                r_rd_pos <= rd_pos;
            end
        end
    end

    // stage register control bits (table data is held in r_mm_q / r_em_q)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_match) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_match) begin
            r_s1_first <= i_in_data.first_byte;
            r_s1_last  <= i_in_data.last_byte;
        end
    end

    // ------------------------------------------------------------------
    // decide stage: alive AND match, early win, failure, end and already-decided handling
    // ------------------------------------------------------------------
    always_comb begin
        logic [NUM_STRINGS-1:0] e_alive;
        logic [PW-1:0]          e_pos;
        logic [4:0]             e_id;
        logic [3:0]             e_len;
        logic                   e_have;
        logic                   e_dec;
        logic [NUM_STRINGS-1:0] cur;
        logic [NUM_STRINGS-1:0] ends;
        logic [4:0]             head_id;
        logic [PW:0]            len_sum;
        logic [3:0]             len_sat;
        logic [PW-1:0]          pos_inc;

        // a new subject starts from cleared state
        e_alive = r_s1_first ? ALL_ALIVE : r_alive;
        e_pos   = r_s1_first ? '0 : r_pos;
        e_id    = r_s1_first ? '0 : r_ended_id;
        e_len   = r_s1_first ? '0 : r_ended_len;
        e_have  = r_s1_first ? 1'b0 : r_have_ended;
        e_dec   = r_s1_first ? 1'b0 : r_decided;

        cur     = e_alive & r_mm_q;
        ends    = r_em_q & cur;
        head_id = f_lowest(cur);
        len_sum = {1'b0, e_pos} + 1'b1;
        len_sat = (int'(len_sum) > LEN_SAT) ? 4'(LEN_SAT) : 4'(len_sum);
        pos_inc = PW'(len_sum);

        n_alive      = e_alive;
        n_pos        = e_pos;
        n_ended_id   = e_id;
        n_ended_len  = e_len;
        n_have_ended = e_have;
        n_decided    = e_dec;
        n_rsp        = '{status: ST_PENDING, string_id: '0, match_length: '0};

        if (e_dec || (int'(e_pos) >= MAX_LEN)) begin
            n_decided    = 1'b1;
            n_rsp.status = ST_DECIDED;
        end else if (cur == '0) begin
            // nothing alive: fall back to the remembered ended string
            n_decided = 1'b1;
            if (e_have) begin
                n_rsp = '{status: ST_MATCHED, string_id: e_id, match_length: e_len};
            end else begin
                n_rsp.status = ST_NOMATCH;
            end
        end else begin
            if (ends != '0) begin
                n_ended_id   = f_lowest(ends);
                n_ended_len  = len_sat;
                n_have_ended = 1'b1;
            end
            if (ends[head_id]) begin
                // lowest alive string ended here: it wins outright
                n_decided = 1'b1;
                n_rsp = '{status: ST_MATCHED, string_id: head_id, match_length: len_sat};
            end else begin
                n_alive = cur;
                n_pos   = pos_inc;
                if (r_s1_last || (int'(pos_inc) >= MAX_LEN)) begin
                    n_decided = 1'b1;
                    if (n_have_ended) begin
                        n_rsp = '{status: ST_MATCHED, string_id: n_ended_id,
                                  match_length: n_ended_len};
                    end else begin
                        n_rsp.status = ST_SHORT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive      <= ALL_ALIVE;
            r_pos        <= '0;
            r_ended_id   <= '0;
            r_ended_len  <= '0;
            r_have_ended <= 1'b0;
            r_decided    <= 1'b0;
        end else if (s1_adv) begin
            r_alive      <= n_alive;
            r_pos        <= n_pos;
            r_ended_id   <= n_ended_id;
            r_ended_len  <= n_ended_len;
            r_have_ended <= n_have_ended;
            r_decided    <= n_decided;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a byte after a decision, without a new subject, reports already decided
    a_after_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_decided && !r_s1_first |=> o_out_data.status == ST_DECIDED)
        else $error("byte after decision not reported as decided");

    // an undecided subject always has at least one live string
    a_alive_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decided |-> r_alive != '0)
        else $error("undecided subject with empty alive mask");

    // a match always consumed at least one byte
    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_MATCHED |-> o_out_data.match_length != '0)
        else $error("match reported with zero length");

    // no subject byte enters while the tables are still being cleared
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |=> !r_s1_valid)
        else $error("request accepted during table clear");

endmodule

/* verif/testbench.sv */
// ============================================================================
// testbench : multi-string prefix matcher self-checking bench
// Loads match/end tables with string dictionaries and streams subject bytes
// through the matcher with random idling on both sides. A scoreboard predicts
// every result and compares it field by field with what the block returns.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::*;

    localparam int MAX_LEN      = 8;
    localparam int NUM_STRINGS  = 32;
    localparam int TBL_DEPTH    = MAX_LEN * 256;
    localparam int MAX_DICT     = 10;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_START   = 780;   // no idling from here on
    localparam int LONG_HOLD    = 150;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 20;    // idle margin after the final drain
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [31:0] STRING_MASK =
        (NUM_STRINGS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_STRINGS) - 32'd1);

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_Z = 8'h7A;

    // how a subject is derived from a dictionary string
    typedef enum int {
        SHAPE_EXACT,
        SHAPE_CUT,
        SHAPE_EXTEND,
        SHAPE_CORRUPT,
        SHAPE_OVERRUN
    } t_subject_shape;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the tables and the subject state, and the queue
    // of results the block still owes.
    // ------------------------------------------------------------------------
    class t_match_scoreboard;
        logic [31:0] match_tbl [TBL_DEPTH];
        logic [31:0] end_tbl   [TBL_DEPTH];
        logic [31:0] alive;
        logic [31:0] ended;
        int unsigned depth;
        int unsigned ended_len;
        bit          have_ended;
        bit          decided;
        t_out_rsp    owed_q [$];
        int unsigned mismatches;

        function new();
            foreach (match_tbl[i]) begin
                match_tbl[i] = '0;
                end_tbl[i]   = '0;
            end
            mismatches = 0;
            start_subject();
        endfunction

        function void start_subject();
            alive      = STRING_MASK;
            depth      = 0;
            ended      = '0;
            ended_len  = 0;
            have_ended = 1'b0;
            decided    = 1'b0;
        endfunction

        function int lowest_bit(logic [31:0] m);
            for (int k = 0; k < 32; k++) begin
                if (m[k]) return k;
            end
            return 0;
        endfunction

        function void owe(logic [2:0] st, int id, int unsigned len);
            t_out_rsp r;
            r.status       = st;
            r.string_id    = 5'(id);
            r.match_length = 4'((len > LEN_SAT) ? LEN_SAT : len);
            owed_q.push_back(r);
        endfunction

        // remembered ended string wins, else the given fallback status
        function void settle(logic [2:0] fallback);
            decided = 1'b1;
            if (have_ended) owe(ST_MATCHED, lowest_bit(ended), ended_len);
            else owe(fallback, 0, 0);
        endfunction

        function void note_request(t_in_req rq);
            int unsigned idx;
            logic [31:0] cur;
            logic [31:0] ends;
            logic [31:0] head;
            if (rq.command == CMD_WRITE) begin
                if (rq.position < MAX_LEN) begin
                    idx = {rq.position, rq.byte_value};
                    match_tbl[idx] = rq.match_mask & STRING_MASK;
                    end_tbl[idx]   = rq.end_mask & STRING_MASK;
                end
                return;
            end
            if (rq.first_byte) start_subject();
            if (decided || depth >= MAX_LEN) begin
                decided = 1'b1;
                owe(ST_DECIDED, 0, 0);
                return;
            end
            idx = depth * 256 + rq.byte_value;
            cur = alive & match_tbl[idx];
            if (cur == '0) begin
                settle(ST_NOMATCH);
                return;
            end
            ends = end_tbl[idx] & cur;
            if (ends != '0) begin
                head       = cur & (~cur + 32'd1);
                ended      = ends;
                ended_len  = depth + 1;
                have_ended = 1'b1;
                // lowest alive string just ended: nothing can beat it
                if ((ends & head) != '0) begin
                    decided = 1'b1;
                    owe(ST_MATCHED, lowest_bit(head), ended_len);
                    return;
                end
            end
            alive = cur;
            depth++;
            if (rq.last_byte || depth >= MAX_LEN) begin
                settle(ST_SHORT);
                return;
            end
            owe(ST_PENDING, 0, 0);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("%0t MISMATCH %s: got %0d want %0d", $time, what, got, want);
        endtask

        task check_result(t_out_rsp got);
            t_out_rsp want;
            if (owed_q.size() == 0) begin
                report_mismatch("unexpected result, status", got.status, 0);
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.string_id !== want.string_id)
                report_mismatch("string_id", got.string_id, want.string_id);
            if (got.match_length !== want.match_length)
                report_mismatch("match_length", got.match_length, want.match_length);
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_rsp out_data;

    t_match_scoreboard sb;

    int unsigned requests_sent = 0;
    int unsigned cycle_count   = 0;
    bit          quiet_tail    = 1'b0;  // set late in the run: no idling at all
    bit          long_hold_req = 1'b0;  // asks the result side for a long hold-off

    // current dictionary
    logic [7:0] dict_text [MAX_DICT][MAX_LEN];
    int         dict_len  [MAX_DICT];
    int         dict_count;
    logic [7:0] alphabet  [4];

    multi_string_prefix_matcher_top #(
        .MAX_LEN     (MAX_LEN),
        .NUM_STRINGS (NUM_STRINGS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop. Covers the table sweep after reset with lots of margin over
    // the slowest legal run with every stall at its longest.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    // ------------------------------------------------------------------------
    // Result side: ready toggles at the falling edge. Random stall bursts, a
    // long hold-off on request, none once the tail starts.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. All tasks are entered and left at a falling edge, so
    // valid gets at most one update per step.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_in_req rq);
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(rq);
        requests_sent++;
        @(negedge clk);
        // random idle burst on the request side
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    // hold the request side until every owed result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_write(input logic [2:0] p, input logic [7:0] b,
                              input logic [31:0] mm, input logic [31:0] em);
        t_in_req rq;
        rq.command    = CMD_WRITE;
        rq.position   = p;
        rq.byte_value = b;
        rq.match_mask = mm;
        rq.end_mask   = em;
        rq.first_byte = 1'($urandom);
        rq.last_byte  = 1'($urandom);
        send_request(rq);
    endtask

    // unused fields of a subject byte carry random junk
    task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last);
        t_in_req rq;
        rq.command    = CMD_MATCH;
        rq.position   = 3'($urandom);
        rq.byte_value = b;
        rq.match_mask = $urandom;
        rq.end_mask   = $urandom;
        rq.first_byte = is_first;
        rq.last_byte  = is_last;
        send_request(rq);
    endtask

    task automatic send_noise();
        t_in_req rq;
        rq.command    = 1'($urandom);
        rq.position   = 3'($urandom);
        rq.byte_value = 8'($urandom);
        rq.match_mask = $urandom;
        rq.end_mask   = $urandom;
        rq.first_byte = 1'($urandom);
        rq.last_byte  = 1'($urandom);
        send_request(rq);
    endtask

    // Directed: one small string set that hits each decision path.
    //   string 0 dies at the second byte, string 2 ends there, string 1 ends
    //   at the third 'a', string 31 runs on through 'b' and 'a' to MAX_LEN.
    task automatic run_directed();
        send_write(3'd0, CH_A, 32'hFFFF_FFFF, 32'h0000_0000);
        send_write(3'd1, CH_A, 32'hFFFF_FFFE, 32'h0000_0004);
        send_write(3'd2, CH_A, 32'h8000_0002, 32'h0000_0002);
        send_write(3'd2, CH_B, 32'h8000_0000, 32'h0000_0000);
        for (int p = 3; p < MAX_LEN; p++) send_write(3'(p), CH_A, 32'h8000_0000, '0);
        send_write(3'd7, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
        // last byte before any string ended: too short
        send_byte(CH_A, 1'b1, 1'b1);
        // string 2 ended but was not lowest; failure on 'z' returns it
        send_byte(CH_A, 1'b1, 1'b0);
        send_byte(CH_A, 1'b0, 1'b0);
        send_byte(CH_Z, 1'b0, 1'b0);
        // lowest alive string ends: immediate match, then a byte after decision
        send_byte(CH_A, 1'b1, 1'b0);
        send_byte(CH_A, 1'b0, 1'b0);
        send_byte(CH_A, 1'b0, 1'b0);
        send_byte(CH_A, 1'b0, 1'b1);
        // dead on the first byte: no match
        send_byte(CH_Z, 1'b1, 1'b1);
        // MAX_LEN consumed resolves to string 2; the ninth byte is already decided
        send_byte(CH_A, 1'b1, 1'b0);
        send_byte(CH_A, 1'b0, 1'b0);
        send_byte(CH_B, 1'b0, 1'b0);
        for (int i = 3; i <= MAX_LEN; i++) send_byte(CH_A, 1'b0, 1'b0);
    endtask

    // Builds a random dictionary over a 4-byte alphabet with shared prefixes,
    // then writes every table entry it touches.
    task automatic load_dictionary();
        bit [31:0] mm_acc  [TBL_DEPTH];
        bit [31:0] em_acc  [TBL_DEPTH];
        bit        touched [TBL_DEPTH];
        bit        id_taken [32];
        int        id;
        int        len;
        int        prev;
        int        share;
        int        idx;
        foreach (alphabet[i]) alphabet[i] = 8'($urandom);
        dict_count = $urandom_range(2, MAX_DICT);
        for (int s = 0; s < dict_count; s++) begin
            do id = $urandom_range(0, NUM_STRINGS - 1); while (id_taken[id]);
            id_taken[id] = 1'b1;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN)
                                              : $urandom_range(1, 4);
            share = 0;
            prev  = 0;
            if (s > 0 && $urandom_range(0, 1) == 1) begin
                prev  = $urandom_range(0, s - 1);
                share = $urandom_range(0, (len < dict_len[prev]) ? len : dict_len[prev]);
            end
            dict_len[s] = len;
            for (int p = 0; p < len; p++) begin
                if (p < share) dict_text[s][p] = dict_text[prev][p];
                else dict_text[s][p] = alphabet[$urandom_range(0, 3)];
                idx = p * 256 + dict_text[s][p];
                mm_acc[idx][id] = 1'b1;
                touched[idx]    = 1'b1;
                if (p == len - 1) em_acc[idx][id] = 1'b1;
            end
        end
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (touched[i]) send_write(3'(i / 256), 8'(i % 256), mm_acc[i], em_acc[i]);
        end
    endtask

    task automatic send_subject();
        logic [7:0]     text [12];
        int             pick;
        int             len;
        bit             with_last;
        t_subject_shape shape;
        pick = $urandom_range(0, dict_count - 1);
        len  = dict_len[pick];
        for (int i = 0; i < 12; i++) begin
            if (i < len) text[i] = dict_text[pick][i];
            else text[i] = alphabet[$urandom_range(0, 3)];
        end
        shape = t_subject_shape'($urandom_range(0, 4));
        case (shape)
            SHAPE_CUT: begin
                if (len > 1) len = $urandom_range(1, len - 1);
            end
            SHAPE_EXTEND: begin
                len = len + $urandom_range(1, 3);
            end
            SHAPE_CORRUPT: begin
                if ($urandom_range(0, 1) == 1)
                    text[$urandom_range(0, len - 1)] = alphabet[$urandom_range(0, 3)];
                else
                    text[$urandom_range(0, len - 1)] = 8'($urandom);
            end
            SHAPE_OVERRUN: begin
                len = $urandom_range(MAX_LEN + 1, 12);
            end
            default: ;
        endcase
        with_last = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++)
            send_byte(text[i], i == 0, with_last && (i == len - 1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        // Random phases: a fresh dictionary, then mostly well-formed subjects
        // with some noise mixed in. Stale entries of older sets stay in the
        // tables and make for extra partial matches.
        phase = 0;
        while (requests_sent < RANDOM_ITEMS) begin
            if (requests_sent >= TAIL_START) quiet_tail = 1'b1;
            repeat ($urandom_range(0, 3)) send_noise();
            load_dictionary();
            // result side holds off while requests keep coming: block fills up
            if (phase == 1) long_hold_req = 1'b1;
            repeat ($urandom_range(15, 30)) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else send_subject();
            end
            // let everything come back before the next set
            if (phase == 2) wait_drained();
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
design/msm_pkg.sv
design/multi_string_prefix_matcher_top.sv
verif/testbench.sv
